// ===== rtl/bfiq_pkg.sv =====
// Shared constants and types for the bloom filter insert/query unit.
// No dependencies; used by bfiq_req_if, the unit and the bench.
package bfiq_pkg;

   localparam int MAX_FILTER_BITS = 1048576;
   localparam int MAX_HASHES      = 32;

   localparam int HASH_W        = 64;
   localparam int WORD_W        = 64;
   localparam int WORD_IDX_W    = $clog2(WORD_W);
   localparam int STORE_WORDS   = MAX_FILTER_BITS / WORD_W;
   localparam int ADDR_W        = $clog2(STORE_WORDS);
   localparam int DIV_CNT_W     = $clog2(HASH_W);
   localparam int MIN_FILTER_BITS = 64;

   localparam int FILTER_SIZE_W = 21;
   localparam int HASH_COUNT_W  = 6;
   localparam int CSR_DATA_W    = 21;
   localparam int CSR_INDEX_W   = 1;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_SIZE = 1'b0,
      CSR_HASH_COUNT  = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/bfiq_req_if.sv =====
// Request channel: operation and two hash words with valid/ready.
// Depends on bfiq_pkg.
interface bfiq_req_if import bfiq_pkg::*;;
   logic              valid;
   logic              ready;
   logic              operation;
   logic [HASH_W-1:0] hash_a;
   logic [HASH_W-1:0] hash_b;

   modport source (output valid, operation, hash_a, hash_b, input ready);
   modport sink   (input valid, operation, hash_a, hash_b, output ready);
endinterface

// ===== rtl/bfiq_rsp_if.sv =====
// Response channel: query result word with valid/ready.
// Depends on nothing but the handshake convention of bfiq_req_if.
interface bfiq_rsp_if;
   logic valid;
   logic ready;
   logic present;

   modport source (output valid, present, input ready);
   modport sink   (input valid, present, output ready);
endinterface

// ===== rtl/bfiq_ram.sv =====
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
module bfiq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/bloom_filter_insert_query_unit.sv =====
// Bloom filter insert/query over a 16384 x 64 bit store, double hashing.
// Each word is accepted, then reduced by the bit-serial remainder unit, then
// probed through the single store port: a read, then a check/write back per
// probe. A query stops at its first clear bit and posts its answer from
// ST_RESPOND once the result slot drains; a new word is taken only in ST_IDLE.
// After reset a clearing pass zeros the store, req_chan.ready stays low.
module bloom_filter_insert_query_unit import bfiq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bfiq_req_if.sink               req_chan,
   bfiq_rsp_if.source             rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_RESPOND
   } state_type;

   state_type               state_ff;
   logic [FILTER_SIZE_W-1:0] filter_size_ff;
   logic [HASH_COUNT_W-1:0]  hash_count_ff;
   logic [ADDR_W-1:0]        clr_addr_ff;

   op_type                   op_ff;
   logic [HASH_W-1:0]        hash_a_ff, hash_b_ff;
   logic [FILTER_SIZE_W-1:0] size_ff;
   logic [HASH_COUNT_W-1:0]  hcnt_ff;
   logic [HASH_COUNT_W-1:0]  probe_cnt_ff;
   logic [DIV_CNT_W-1:0]     div_cnt_ff;
   logic [FILTER_SIZE_W-1:0] rem_a_ff, rem_b_ff;
   logic [FILTER_SIZE_W-1:0] pos_ff, step_ff;
   logic                     result_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_present_ff;

   logic [FILTER_SIZE_W-1:0] rem_a_in, rem_b_in, pos_in;
   logic [FILTER_SIZE_W-1:0] rem_a_sh, rem_b_sh, pos_sum;
   logic [FILTER_SIZE_W-1:0] size_in;
   logic [HASH_COUNT_W-1:0]  hcnt_in;
   logic [HASH_COUNT_W-1:0]  probe_cnt_in;
   logic                     req_fire;
   logic                     rsp_post;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [WORD_W-1:0] ram_rd_data;
   logic              probe_bit;

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign req_fire        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.present = rsp_present_ff;

   // wait for the output word slot to drain
   assign rsp_post = (state_ff == ST_RESPOND) && (!rsp_valid_ff || rsp_chan.ready);

   // Effective modulus and probe count, clamped at accept time.
   always_comb begin
      if (filter_size_ff < FILTER_SIZE_W'(MIN_FILTER_BITS)) begin
         size_in = FILTER_SIZE_W'(MIN_FILTER_BITS);
      end else if (filter_size_ff > FILTER_SIZE_W'(MAX_FILTER_BITS)) begin
         size_in = FILTER_SIZE_W'(MAX_FILTER_BITS);
      end else begin
         size_in = filter_size_ff;
      end
      if (hash_count_ff > HASH_COUNT_W'(MAX_HASHES)) begin
         hcnt_in = HASH_COUNT_W'(MAX_HASHES);
      end else begin
         hcnt_in = hash_count_ff;
      end
   end

   // Restoring remainder, one hash bit per cycle, MSB first. rem < size, so
   // the dropped top bit is always zero.
   always_comb begin
      rem_a_sh = {rem_a_ff[FILTER_SIZE_W-2:0], hash_a_ff[HASH_W-1]};
      rem_b_sh = {rem_b_ff[FILTER_SIZE_W-2:0], hash_b_ff[HASH_W-1]};
      rem_a_in = (rem_a_sh >= size_ff) ? rem_a_sh - size_ff : rem_a_sh;
      rem_b_in = (rem_b_sh >= size_ff) ? rem_b_sh - size_ff : rem_b_sh;
      // pos, step < size, so one conditional subtract keeps pos in range
      pos_sum      = pos_ff + step_ff;
      pos_in       = (pos_sum >= size_ff) ? pos_sum - size_ff : pos_sum;
      probe_cnt_in = probe_cnt_ff + HASH_COUNT_W'(1);
   end

   assign probe_bit = ram_rd_data[pos_ff[WORD_IDX_W-1:0]];

   always_comb begin
      ram_rd_en = (state_ff == ST_PROBE_RD);
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = (state_ff == ST_PROBE_CHK) && (op_ff == OP_INSERT);
         ram_wr_addr = pos_ff[WORD_IDX_W +: ADDR_W];
         ram_wr_data = ram_rd_data | (WORD_W'(1) << pos_ff[WORD_IDX_W-1:0]);
      end
   end

   bfiq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff[WORD_IDX_W +: ADDR_W]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         filter_size_ff <= FILTER_SIZE_W'(MAX_FILTER_BITS);
         hash_count_ff  <= HASH_COUNT_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_FILTER_SIZE: filter_size_ff <= csr_data[FILTER_SIZE_W-1:0];
               CSR_HASH_COUNT:  hash_count_ff  <= csr_data[HASH_COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_post) begin
            rsp_valid_ff   <= 1'b1;
            rsp_present_ff <= result_ff;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               if (clr_addr_ff == ADDR_W'(STORE_WORDS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff      <= op_type'(req_chan.operation);
                  hash_a_ff  <= req_chan.hash_a;
                  hash_b_ff  <= req_chan.hash_b;
                  size_ff    <= size_in;
                  hcnt_ff    <= hcnt_in;
                  rem_a_ff   <= '0;
                  rem_b_ff   <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               rem_a_ff   <= rem_a_in;
               rem_b_ff   <= rem_b_in;
               hash_a_ff  <= {hash_a_ff[HASH_W-2:0], 1'b0};
               hash_b_ff  <= {hash_b_ff[HASH_W-2:0], 1'b0};
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(HASH_W - 1)) begin
                  pos_ff       <= rem_a_in;
                  step_ff      <= rem_b_in;
                  probe_cnt_ff <= '0;
                  result_ff    <= 1'b1;
                  if (hcnt_ff != '0) begin
                     state_ff <= ST_PROBE_RD;
                  end else if (op_ff == OP_QUERY) begin
                     state_ff <= ST_RESPOND;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_PROBE_RD: begin
               state_ff <= ST_PROBE_CHK;
            end
            ST_PROBE_CHK: begin
               pos_ff       <= pos_in;
               probe_cnt_ff <= probe_cnt_in;
               if (op_ff == OP_QUERY && !probe_bit) begin
                  result_ff <= 1'b0;
                  state_ff  <= ST_RESPOND;
               end else if (probe_cnt_in == hcnt_ff) begin
                  state_ff <= (op_ff == OP_QUERY) ? ST_RESPOND : ST_IDLE;
               end else begin
                  state_ff <= ST_PROBE_RD;
               end
            end
            ST_RESPOND: begin
               if (rsp_post) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_wr_only_insert: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff != ST_CLEAR) |-> (op_ff == OP_INSERT))
      else $error("store written outside insert");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE_RD) |-> (pos_ff < size_ff && step_ff < size_ff))
      else $error("probe position or step not below filter size");

   a_probe_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE_RD || state_ff == ST_PROBE_CHK) |-> (probe_cnt_ff < hcnt_ff))
      else $error("probe count overran hash count");

   a_respond_posts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESPOND) |=> (state_ff == ST_RESPOND || rsp_valid_ff))
      else $error("query left respond state without a result word");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> (state_ff == ST_CLEAR || state_ff == ST_IDLE))
      else $error("left clearing pass to a busy state");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bloom_filter_insert_query_unit: directed rows, then random phases.
// Depends on bfiq_pkg, bfiq_req_if, bfiq_rsp_if and the unit itself.
module tb_top;
   import bfiq_pkg::*;

   localparam int SETTLE_CYCLES = 160;
   localparam int RANDOM_PHASES = 10;
   localparam int WORDS_PER_PHASE = 70;
   localparam int DIRECTED_ROWS = 23;
   localparam logic [HASH_W-1:0] ALL_ONES = {HASH_W{1'b1}};

   typedef struct {
      logic [CSR_DATA_W-1:0]   fsize;
      logic [HASH_COUNT_W-1:0] hcount;
      op_type                  op;
      logic [HASH_W-1:0]       ha;
      logic [HASH_W-1:0]       hb;
      bit                      typed;
      bit                      want_present;
   } vector_row_type;

   typedef struct {
      logic [HASH_W-1:0] ha;
      logic [HASH_W-1:0] hb;
   } hash_pair_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   bfiq_req_if req_chan ();
   bfiq_rsp_if rsp_chan ();

   bloom_filter_insert_query_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // shadow of the filter and its registers
   bit filter_bits [MAX_FILTER_BITS];
   logic [FILTER_SIZE_W-1:0] cfg_filter_size = FILTER_SIZE_W'(MAX_FILTER_BITS);
   logic [HASH_COUNT_W-1:0] cfg_hash_count = HASH_COUNT_W'(1);

   bit present_expected [$];
   hash_pair_type inserted_pairs [$];
   bit quiet = 1'b0;
   int fail_count = 0;
   int inserts_sent = 0;
   int queries_sent = 0;
   int answers_checked = 0;
   int settings_written = 0;

   vector_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset settings: full size, one probe
      '{21'd1048576, 6'd1, OP_QUERY, 64'd0, 64'd0, 1'b1, 1'b0},
      '{21'd1048576, 6'd1, OP_QUERY, ALL_ONES, ALL_ONES, 1'b1, 1'b0},
      '{21'd1048576, 6'd1, OP_INSERT, 64'd0, 64'd0, 1'b0, 1'b0},
      '{21'd1048576, 6'd1, OP_QUERY, 64'd0, ALL_ONES, 1'b1, 1'b1},
      '{21'd1048576, 6'd1, OP_INSERT, ALL_ONES, 64'd0, 1'b0, 1'b0},
      '{21'd1048576, 6'd1, OP_QUERY, ALL_ONES, 64'd12345, 1'b1, 1'b1},
      // smallest filter, most probes; earlier bits stay put
      '{21'd64, 6'd32, OP_QUERY, 64'd64, 64'd0, 1'b1, 1'b1},
      '{21'd64, 6'd32, OP_QUERY, 64'd1, 64'd1, 1'b1, 1'b0},
      '{21'd64, 6'd32, OP_INSERT, 64'd1, 64'd1, 1'b0, 1'b0},
      '{21'd64, 6'd32, OP_QUERY, 64'd33, 64'd65, 1'b0, 1'b0},
      '{21'd64, 6'd32, OP_QUERY, 64'd1, 64'd65, 1'b1, 1'b1},
      '{21'd64, 6'd32, OP_INSERT, ALL_ONES, ALL_ONES, 1'b0, 1'b0},
      '{21'd64, 6'd32, OP_QUERY, 64'd33, 64'd65, 1'b0, 1'b0},
      // size below minimum, zero probes: always present, insert is a no-op
      '{21'd0, 6'd0, OP_QUERY, 64'h8000_0000_0000_0000, 64'd3, 1'b1, 1'b1},
      '{21'd0, 6'd0, OP_INSERT, 64'd5, 64'd7, 1'b0, 1'b0},
      '{21'd0, 6'd0, OP_QUERY, ALL_ONES, ALL_ONES, 1'b1, 1'b1},
      // both registers above their limits
      '{21'h1F_FFFF, 6'd63, OP_QUERY, 64'd123, 64'd1, 1'b1, 1'b0},
      '{21'h1F_FFFF, 6'd63, OP_INSERT, 64'd123, 64'd1048577, 1'b0, 1'b0},
      '{21'h1F_FFFF, 6'd63, OP_QUERY, 64'd123, 64'd1, 1'b1, 1'b1},
      '{21'h1F_FFFF, 6'd63, OP_QUERY, 64'd1048575, 64'd1048575, 1'b0, 1'b0},
      '{21'h1F_FFFF, 6'd63, OP_QUERY, 64'd5, 64'd7, 1'b0, 1'b0},
      '{21'd100, 6'd3, OP_INSERT, 64'hDEAD_BEEF_0123_4567, 64'h0F0F_F0F0_1234_8765, 1'b0, 1'b0},
      '{21'd100, 6'd3, OP_QUERY, 64'hDEAD_BEEF_0123_4567, 64'h0F0F_F0F0_1234_8765, 1'b0, 1'b0}
   };

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [HASH_W-1:0] effective_span();
      logic [HASH_W-1:0] span;
      span = HASH_W'(cfg_filter_size);
      if (span < HASH_W'(MIN_FILTER_BITS)) span = HASH_W'(MIN_FILTER_BITS);
      if (span > HASH_W'(MAX_FILTER_BITS)) span = HASH_W'(MAX_FILTER_BITS);
      return span;
   endfunction

   // sets the probed bits on insert; on query returns 0 at the first clear bit
   function automatic bit probe_filter(op_type op, logic [HASH_W-1:0] ha,
                                       logic [HASH_W-1:0] hb);
      logic [HASH_W-1:0] span, probes, base, stride, pos, i;
      bit hit;
      span = effective_span();
      probes = HASH_W'(cfg_hash_count);
      if (probes > HASH_W'(MAX_HASHES)) probes = HASH_W'(MAX_HASHES);
      base = ha % span;
      stride = hb % span;
      hit = 1'b1;
      for (i = '0; i < probes; i++) begin
         pos = (base + i * stride) % span;
         if (op == OP_INSERT) begin
            filter_bits[pos[ADDR_W+WORD_IDX_W-1:0]] = 1'b1;
         end else if (!filter_bits[pos[ADDR_W+WORD_IDX_W-1:0]]) begin
            hit = 1'b0;
            break;
         end
      end
      return hit;
   endfunction

   function automatic logic [HASH_W-1:0] pick_hash();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL_ONES;
         2: return effective_span() * HASH_W'($urandom_range(0, 1000));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic log_failure(string what);
      fail_count++;
      if (fail_count <= 10) $display("ERROR at %0t: %s", $time, what);
   endtask

   task automatic send_word(op_type op, logic [HASH_W-1:0] ha, logic [HASH_W-1:0] hb,
                            bit typed, bit want_present);
      int gap;
      bit answer;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.hash_a <= ha;
      req_chan.hash_b <= hb;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      answer = probe_filter(op, ha, hb);
      if (op == OP_QUERY) begin
         present_expected.push_back(typed ? want_present : answer);
         queries_sent++;
      end else begin
         inserts_sent++;
      end
   endtask

   // inserts leave no answer behind, so allow a full word time after the last one
   task automatic drain_block();
      req_chan.valid <= 1'b0;
      while (present_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(logic [CSR_DATA_W-1:0] fsize, logic [CSR_DATA_W-1:0] hdata);
      drain_block();
      csr_write_en <= 1'b1;
      csr_index <= CSR_FILTER_SIZE;
      csr_data <= fsize;
      @(posedge clock);
      cfg_filter_size = fsize;
      csr_index <= CSR_HASH_COUNT;
      csr_data <= hdata;
      @(posedge clock);
      cfg_hash_count = hdata[HASH_COUNT_W-1:0];
      csr_write_en <= 1'b0;
      settings_written++;
   endtask

   task automatic issue_random_word();
      int pick;
      hash_pair_type pair;
      pick = $urandom_range(0, 99);
      if (pick < 40 || inserted_pairs.size() == 0) begin
         pair.ha = pick_hash();
         pair.hb = pick_hash();
         inserted_pairs.push_back(pair);
         send_word(OP_INSERT, pair.ha, pair.hb, 1'b0, 1'b0);
      end else if (pick < 75) begin
         pair = inserted_pairs[$urandom_range(0, inserted_pairs.size() - 1)];
         send_word(OP_QUERY, pair.ha, pair.hb, 1'b0, 1'b0);
      end else if (pick < 85) begin
         // near miss: a known item with one step bit flipped
         pair = inserted_pairs[$urandom_range(0, inserted_pairs.size() - 1)];
         pair.hb[$urandom_range(0, HASH_W - 1)] ^= 1'b1;
         send_word(OP_QUERY, pair.ha, pair.hb, 1'b0, 1'b0);
      end else begin
         send_word(OP_QUERY, pick_hash(), pick_hash(), 1'b0, 1'b0);
      end
   endtask

   // result side: random stall before each word, then hold ready until one arrives
   initial begin
      int stall;
      bit want;
      rsp_chan.ready = 1'b0;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         if (present_expected.size() == 0) begin
            log_failure($sformatf("answer with none pending: present=%0b", rsp_chan.present));
         end else begin
            want = present_expected.pop_front();
            answers_checked++;
            if (rsp_chan.present !== want)
               log_failure($sformatf("present mismatch: expected %0b, got %0b",
                                     want, rsp_chan.present));
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] fsize;
      logic [CSR_DATA_W-1:0] hdata;
      logic [HASH_COUNT_W-1:0] hcount;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_FILTER_SIZE;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_INSERT;
      req_chan.hash_a = '0;
      req_chan.hash_b = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].fsize != cfg_filter_size ||
             directed_rows[r].hcount != cfg_hash_count)
            load_config(directed_rows[r].fsize, CSR_DATA_W'(directed_rows[r].hcount));
         send_word(directed_rows[r].op, directed_rows[r].ha, directed_rows[r].hb,
                   directed_rows[r].typed, directed_rows[r].want_present);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin fsize = 21'd64;      hcount = 6'd32; end
            1: begin fsize = 21'h1F_FFFF; hcount = 6'd63; end
            2: begin fsize = 21'd0;       hcount = 6'd1;  end
            3: begin fsize = 21'd1048576; hcount = 6'd0;  end
            default: begin
               // mostly small filters so that bits collide
               fsize = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom_range(0, 2097151))
                                                   : CSR_DATA_W'($urandom_range(64, 4096));
               hcount = ($urandom_range(0, 7) == 0) ? HASH_COUNT_W'($urandom_range(0, 63))
                                                    : HASH_COUNT_W'($urandom_range(1, 16));
            end
         endcase
         // upper data bits of the count write are don't-care
         hdata = CSR_DATA_W'($urandom);
         hdata[HASH_COUNT_W-1:0] = hcount;
         quiet = 1'b0;
         load_config(fsize, hdata);
         quiet = ($urandom_range(0, 3) == 0);
         repeat (WORDS_PER_PHASE) issue_random_word();
      end

      drain_block();
      if (present_expected.size() != 0) log_failure("answers still pending at end");
      $display("Sent %0d inserts and %0d queries over %0d filter settings.",
               inserts_sent, queries_sent, settings_written);
      $display("Checked %0d query answers, %0d failures.", answers_checked, fail_count);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bfiq_pkg.sv
rtl/bfiq_req_if.sv
rtl/bfiq_rsp_if.sv
rtl/bfiq_ram.sv
rtl/bloom_filter_insert_query_unit.sv
bench/tb_top.sv
